@@ sv/ptp_pkg.sv @@
// ----------------------------------------------------------------------------
// ptp_pkg
// Shared types and constants of the point transform and projection block.
// ----------------------------------------------------------------------------
package ptp_pkg;

  localparam int unsigned DivBits  = 32;
  localparam logic signed [31:0] MinDepth = 32'sd256;
  localparam logic [31:0] ScaleNum = 32'h0100_0000;
  localparam int unsigned AddrBits = 6;

  // Register byte addresses
  typedef enum logic [AddrBits-1:0] {
    REG_MAT_ROW0    = 6'h00,
    REG_MAT_ROW1    = 6'h08,
    REG_MAT_ROW2    = 6'h10,
    REG_TRANS_X     = 6'h18,
    REG_TRANS_Y     = 6'h20,
    REG_TRANS_DEPTH = 6'h28,
    REG_CENTER_X    = 6'h30,
    REG_CENTER_Y    = 6'h38
  } reg_addr_t;

  typedef struct packed {
    logic [47:0]        mat_row0;
    logic [47:0]        mat_row1;
    logic [47:0]        mat_row2;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_depth;
    logic [11:0]        center_x;
    logic [11:0]        center_y;
  } cfg_t;

  // Classified point handed from the front part to the back part
  typedef struct packed {
    logic               visible;
    logic signed [31:0] num_x;
    logic signed [31:0] num_y;
    logic signed [31:0] depth;
  } point_t;

  typedef struct packed {
    logic        visible;
    logic [31:0] screen_x;
    logic [31:0] screen_y;
    logic [16:0] scale_factor;
    logic [31:0] depth_out;
  } result_t;

endpackage

@@ sv/ptp_if.sv @@
// ----------------------------------------------------------------------------
// ptp_in_if / ptp_out_if
// Valid/ready channels carrying points in and projected results out.
// ----------------------------------------------------------------------------
interface ptp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_height;
  logic signed [31:0] pos_z;
  modport source (output valid, pos_x, pos_height, pos_z, input ready);
  modport sink (input valid, pos_x, pos_height, pos_z, output ready);
endinterface

interface ptp_out_if;
  logic               valid;
  logic               ready;
  logic               visible;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic [16:0]        scale_factor;
  logic signed [31:0] depth_out;
  modport source (output valid, visible, screen_x, screen_y, scale_factor, depth_out,
                  input ready);
  modport sink (input valid, visible, screen_x, screen_y, scale_factor, depth_out,
                output ready);
endinterface

@@ sv/point_transform_project_unit.sv @@
// ----------------------------------------------------------------------------
// point_transform_project_unit
// Fixed point camera transform and perspective projection of 3D points.
// ----------------------------------------------------------------------------
// Points enter on pin (valid/ready) as 16.16 x, height, z; one result per
// point leaves on pout in the same order. The APB port loads the 3x3 camera
// matrix, translation and screen center; the user must load them only while
// no point is in flight, as the block itself does not enforce it.
// Throughput: one transaction per cycle while pout is not stalled. The product
// register loads at the accept edge; one magnitude stage, 32 restoring divide
// stages (one quotient bit each, three dividers side by side) and the output
// register follow; the divide pipeline sets the latency.
// Reset clears the valid bits and configuration and empties the pipeline. When
// the receiver stalls, the output register holds its transaction; empty stages
// keep moving up; once the last divide stage holds a transaction, the pipeline
// freezes, and with the front stage full pin.ready drops until pout is taken.
// ----------------------------------------------------------------------------
module point_transform_project_unit (
  input  logic                         clk,
  input  logic                         rst,
  ptp_in_if.sink                       pin,
  ptp_out_if.source                    pout,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ptp_pkg::AddrBits-1:0] paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);
  import ptp_pkg::*;

  cfg_t    cfg;
  logic    pt_valid;
  point_t  pt;
  logic    adv;
  result_t res;

  ptp_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  ptp_front u_front (
    .clk, .rst, .cfg, .pin, .pt_valid, .pt, .adv
  );

  ptp_back u_back (
    .clk, .rst, .cfg, .pt_valid, .pt, .adv,
    .res_valid(pout.valid), .res, .res_ready(pout.ready)
  );

  assign pout.visible      = res.visible;
  assign pout.screen_x     = res.screen_x;
  assign pout.screen_y     = res.screen_y;
  assign pout.scale_factor = res.scale_factor;
  assign pout.depth_out    = res.depth_out;
endmodule

@@ sv/ptp_regs.sv @@
// ----------------------------------------------------------------------------
// ptp_regs
// APB register file holding the camera matrix, translation and center.
// ----------------------------------------------------------------------------
module ptp_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ptp_pkg::AddrBits-1:0]    paddr,
  input  logic [63:0]                     pwdata,
  output logic [63:0]                     prdata,
  output logic                            pready,
  output ptp_pkg::cfg_t                   cfg
);
  import ptp_pkg::*;

  logic wr;
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (paddr)
        REG_MAT_ROW0:    cfg.mat_row0 <= pwdata[47:0];
        REG_MAT_ROW1:    cfg.mat_row1 <= pwdata[47:0];
        REG_MAT_ROW2:    cfg.mat_row2 <= pwdata[47:0];
        REG_TRANS_X:     cfg.trans_x <= pwdata[31:0];
        REG_TRANS_Y:     cfg.trans_y <= pwdata[31:0];
        REG_TRANS_DEPTH: cfg.trans_depth <= pwdata[31:0];
        REG_CENTER_X:    cfg.center_x <= pwdata[11:0];
        REG_CENTER_Y:    cfg.center_y <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr)
      REG_MAT_ROW0:    prdata = {16'h0, cfg.mat_row0};
      REG_MAT_ROW1:    prdata = {16'h0, cfg.mat_row1};
      REG_MAT_ROW2:    prdata = {16'h0, cfg.mat_row2};
      REG_TRANS_X:     prdata = {32'h0, cfg.trans_x};
      REG_TRANS_Y:     prdata = {32'h0, cfg.trans_y};
      REG_TRANS_DEPTH: prdata = {32'h0, cfg.trans_depth};
      REG_CENTER_X:    prdata = {52'h0, cfg.center_x};
      REG_CENTER_Y:    prdata = {52'h0, cfg.center_y};
      default:         prdata = '0;
    endcase
  end
endmodule

@@ sv/ptp_front.sv @@
// ----------------------------------------------------------------------------
// ptp_front
// Transform front end: registered matrix products, a combinational sum and the visibility check.
// ----------------------------------------------------------------------------
module ptp_front (
  input  logic            clk,
  input  logic            rst,
  input  ptp_pkg::cfg_t   cfg,
  ptp_in_if.sink          pin,
  output logic            pt_valid,
  output ptp_pkg::point_t pt,
  input  logic            adv
);
  import ptp_pkg::*;

  logic               s1_valid;
  logic signed [31:0] prod [3][3];
  logic signed [31:0] pv [3];
  logic signed [15:0] coef [3][3];
  logic signed [31:0] acc [3];
  logic signed [31:0] wx, wy, dep;

  assign pin.ready = adv || !s1_valid;

  // Shift inputs and split coefficients
  always_comb begin
    pv[0] = pin.pos_x >>> 8;
    pv[1] = pin.pos_height >>> 8;
    pv[2] = pin.pos_z >>> 8;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        coef[r][k] = (r == 0) ? cfg.mat_row0[16*k +: 16] :
                     (r == 1) ? cfg.mat_row1[16*k +: 16] : cfg.mat_row2[16*k +: 16];
      end
    end
  end

  // Stage 1: register the nine products
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pin.ready) begin
      s1_valid <= pin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pin.ready) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod[r][k] <= 32'(pv[k] * coef[r][k]);
        end
      end
    end
  end

  // Sum shifted products with translation
  always_comb begin
    acc[0] = cfg.trans_x;
    acc[1] = cfg.trans_y;
    acc[2] = cfg.trans_depth;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        acc[r] = acc[r] + (prod[r][k] >>> 8);
      end
    end
    wx = acc[0];
    wy = acc[1];
    dep = acc[2];
  end

  assign pt_valid = s1_valid;
  assign pt.visible = (dep >= MinDepth);
  assign pt.num_x = {wx[23:0], 8'h00};
  assign pt.num_y = {wy[23:0], 8'h00};
  assign pt.depth = dep;

  // Hold the stage while the back part cannot take it
  ptp_front_hold_a: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid && $stable(prod[2][2]))
    else $error("front stage dropped a held point");
endmodule

@@ sv/ptp_back.sv @@
// ----------------------------------------------------------------------------
// ptp_back
// Projection back end: pipelined radix-2 dividers and output assembly.
// ----------------------------------------------------------------------------
module ptp_back (
  input  logic            clk,
  input  logic            rst,
  input  ptp_pkg::cfg_t   cfg,
  input  logic            pt_valid,
  input  ptp_pkg::point_t pt,
  output logic            adv,
  output logic            res_valid,
  output ptp_pkg::result_t res,
  input  logic            res_ready
);
  import ptp_pkg::*;

  localparam int N = DivBits;

  // Per-stage division state, one bit of each quotient per stage
  logic [N:0]     v;
  logic [31:0]    d   [N+1];
  logic [31:0]    nx  [N+1];
  logic [31:0]    ny  [N+1];
  logic [31:0]    ns  [N+1];
  logic [31:0]    rx  [N+1];
  logic [31:0]    ry  [N+1];
  logic [31:0]    rs  [N+1];
  logic           vis [N+1];
  logic           sx  [N+1];
  logic           sy  [N+1];
  logic signed [31:0] dep [N+1];
  logic           stall;
  logic [31:0]    qx, qy;

  assign stall = v[N] && res_valid && !res_ready;
  assign adv = !stall;

  // Stage 0: take magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (!stall) begin
      v[0] <= pt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      vis[0] <= pt.visible;
      dep[0] <= pt.depth;
      d[0]   <= pt.depth[31] ? 32'(-pt.depth) : pt.depth;
      sx[0]  <= pt.num_x[31] ^ pt.depth[31];
      sy[0]  <= pt.num_y[31] ^ pt.depth[31];
      nx[0]  <= pt.num_x[31] ? 32'(-pt.num_x) : pt.num_x;
      ny[0]  <= pt.num_y[31] ? 32'(-pt.num_y) : pt.num_y;
      ns[0]  <= ScaleNum;
      rx[0]  <= '0;
      ry[0]  <= '0;
      rs[0]  <= '0;
    end
  end

  // Restoring division steps
  for (genvar i = 0; i < N; i++) begin : g_div
    logic [32:0] tx, ty, ts;
    assign tx = {rx[i], nx[i][31]};
    assign ty = {ry[i], ny[i][31]};
    assign ts = {rs[i], ns[i][31]};
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (!stall) begin
        v[i+1] <= v[i];
      end
    end
    always_ff @(posedge clk) begin
      if (!stall) begin
        d[i+1]   <= d[i];
        vis[i+1] <= vis[i];
        dep[i+1] <= dep[i];
        sx[i+1]  <= sx[i];
        sy[i+1]  <= sy[i];
        if (tx >= {1'b0, d[i]}) begin
          rx[i+1] <= 32'(tx - {1'b0, d[i]});
          nx[i+1] <= {nx[i][30:0], 1'b1};
        end else begin
          rx[i+1] <= tx[31:0];
          nx[i+1] <= {nx[i][30:0], 1'b0};
        end
        if (ty >= {1'b0, d[i]}) begin
          ry[i+1] <= 32'(ty - {1'b0, d[i]});
          ny[i+1] <= {ny[i][30:0], 1'b1};
        end else begin
          ry[i+1] <= ty[31:0];
          ny[i+1] <= {ny[i][30:0], 1'b0};
        end
        if (ts >= {1'b0, d[i]}) begin
          rs[i+1] <= 32'(ts - {1'b0, d[i]});
          ns[i+1] <= {ns[i][30:0], 1'b1};
        end else begin
          rs[i+1] <= ts[31:0];
          ns[i+1] <= {ns[i][30:0], 1'b0};
        end
      end
    end
  end

  assign qx = sx[N] ? 32'(-nx[N]) : nx[N];
  assign qy = sy[N] ? 32'(-ny[N]) : ny[N];

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || res_ready) begin
      res_valid <= v[N];
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || res_ready) begin
      res.visible      <= vis[N];
      res.depth_out    <= dep[N];
      res.screen_x     <= vis[N] ? 32'({20'h0, cfg.center_x} + qx) : '0;
      res.screen_y     <= vis[N] ? 32'({20'h0, cfg.center_y} - qy) : '0;
      res.scale_factor <= vis[N] ? ns[N][16:0] : '0;
    end
  end

  ptp_back_hold_a: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res.depth_out))
    else $error("result changed while stalled");
  ptp_back_vis_a: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.visible |-> res.scale_factor == '0 && res.screen_x == '0)
    else $error("invisible point carries projection");
  ptp_back_flow_a: assert property (@(posedge clk) disable iff (rst)
    stall |=> v[N])
    else $error("pipeline lost a point under stall");
endmodule

@@ sim/tb_point_transform_project_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_point_transform_project_unit
// Self-checking bench for the point transform and projection unit.
// ----------------------------------------------------------------------------
// Loads camera settings over APB while the unit is idle, streams points in
// with random gaps and compares every projected result, field by field,
// against a table value or an in-bench projection model. A directed table
// comes first, then random points under several cameras, extremes included.
// ----------------------------------------------------------------------------
module tb_point_transform_project_unit;
  import ptp_pkg::*;

  localparam int Latency = 34;
  localparam int CycleLimit = 1_000_000;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] h;
    logic signed [31:0] z;
    bit                 typed;
    result_t            res;
  } point_row_t;

  typedef struct {
    bit      typed;
    result_t res;
  } point_tag_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [AddrBits-1:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  ptp_in_if  pin_bus ();
  ptp_out_if pout_bus ();

  point_transform_project_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .pin     (pin_bus.sink),
    .pout    (pout_bus.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cfg_t       cam;
  point_tag_t tag_q[$];
  result_t    result_q[$];
  int         fail_count;
  int         cycle_count;
  bit         stall_req;
  bit         stall_done;
  bit         rx_steady;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // One matrix row applied to the pre-shifted point, plus translation
  function automatic logic [31:0] row_sum(logic [47:0] row, logic [31:0] offs,
                                          logic signed [63:0] pt0,
                                          logic signed [63:0] pt1,
                                          logic signed [63:0] pt2);
    logic [31:0]        acc;
    logic signed [63:0] coef;
    logic signed [63:0] prod;
    logic signed [31:0] low;
    logic signed [31:0] term;
    logic signed [63:0] pt[3];
    pt[0] = pt0;
    pt[1] = pt1;
    pt[2] = pt2;
    acc = offs;
    for (int k = 0; k < 3; k++) begin
      coef = $signed(row[k*16 +: 16]);
      prod = pt[k] * coef;
      low = prod[31:0];
      term = low >>> 8;
      acc = acc + term;
    end
    return acc;
  endfunction

  // Camera transform and perspective projection of one point
  function automatic result_t project_point(logic signed [31:0] x, logic signed [31:0] h,
                                            logic signed [31:0] z);
    logic signed [31:0] sx, sh, sz;
    logic [31:0]        wx, wy, dep, nx32, ny32;
    logic signed [63:0] d, nx, ny, qx, qy, sc;
    result_t            r;
    sx = x >>> 8;
    sh = h >>> 8;
    sz = z >>> 8;
    wx = row_sum(cam.mat_row0, cam.trans_x, sx, sh, sz);
    wy = row_sum(cam.mat_row1, cam.trans_y, sx, sh, sz);
    dep = row_sum(cam.mat_row2, cam.trans_depth, sx, sh, sz);
    d = $signed(dep);
    r = '0;
    r.depth_out = dep;
    if (d >= 64'sd256) begin
      nx32 = wx << 8;
      ny32 = wy << 8;
      nx = $signed(nx32);
      ny = $signed(ny32);
      qx = nx / d;
      qy = ny / d;
      sc = 64'sd16777216 / d;
      r.visible = 1'b1;
      r.screen_x = {20'd0, cam.center_x} + qx[31:0];
      r.screen_y = {20'd0, cam.center_y} - qy[31:0];
      r.scale_factor = sc[16:0];
    end
    return r;
  endfunction

  // Turn each accepted point into an expected result
  always @(posedge clk) begin
    point_tag_t tg;
    if (!rst && pin_bus.valid && pin_bus.ready) begin
      tg = tag_q.pop_front();
      if (tg.typed)
        result_q.push_back(tg.res);
      else
        result_q.push_back(project_point(pin_bus.pos_x, pin_bus.pos_height, pin_bus.pos_z));
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    result_t e;
    if (!rst && pout_bus.valid && pout_bus.ready) begin
      if (result_q.size() == 0) begin
        $error("unexpected result transaction");
        fail_count++;
      end else begin
        e = result_q.pop_front();
        if (pout_bus.visible !== e.visible) begin
          $error("visible: expected %0h actual %0h", e.visible, pout_bus.visible);
          fail_count++;
        end
        if (pout_bus.screen_x !== e.screen_x) begin
          $error("screen_x: expected %0h actual %0h", e.screen_x, pout_bus.screen_x);
          fail_count++;
        end
        if (pout_bus.screen_y !== e.screen_y) begin
          $error("screen_y: expected %0h actual %0h", e.screen_y, pout_bus.screen_y);
          fail_count++;
        end
        if (pout_bus.scale_factor !== e.scale_factor) begin
          $error("scale_factor: expected %0h actual %0h", e.scale_factor,
                 pout_bus.scale_factor);
          fail_count++;
        end
        if (pout_bus.depth_out !== e.depth_out) begin
          $error("depth_out: expected %0h actual %0h", e.depth_out, pout_bus.depth_out);
          fail_count++;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: random ready pattern, one long hold-off on request
  initial begin
    int n;
    pout_bus.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (stall_req && !stall_done) begin
        pout_bus.ready <= 1'b0;
        repeat (300) @(posedge clk);
        stall_done = 1'b1;
      end
      pout_bus.ready <= 1'b1;
      n = $urandom_range(1, 12);
      repeat (n) @(posedge clk);
      n = rx_steady ? 0 : pick_gap();
      if (n > 0) begin
        pout_bus.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  // APB write: setup cycle, then access cycle until pready
  task automatic cfg_write(reg_addr_t addr, logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      REG_MAT_ROW0:    cam.mat_row0 = val[47:0];
      REG_MAT_ROW1:    cam.mat_row1 = val[47:0];
      REG_MAT_ROW2:    cam.mat_row2 = val[47:0];
      REG_TRANS_X:     cam.trans_x = val[31:0];
      REG_TRANS_Y:     cam.trans_y = val[31:0];
      REG_TRANS_DEPTH: cam.trans_depth = val[31:0];
      REG_CENTER_X:    cam.center_x = val[11:0];
      REG_CENTER_Y:    cam.center_y = val[11:0];
      default: ;
    endcase
  endtask

  // Load a full camera setting; junk in the unused upper bits
  task automatic load_camera(logic [47:0] r0, logic [47:0] r1, logic [47:0] r2,
                             logic [31:0] tx, logic [31:0] ty, logic [31:0] td,
                             logic [11:0] cx, logic [11:0] cy);
    cfg_write(REG_MAT_ROW0, {16'($urandom_range(0, 65535)), r0});
    cfg_write(REG_MAT_ROW1, {16'($urandom_range(0, 65535)), r1});
    cfg_write(REG_MAT_ROW2, {16'($urandom_range(0, 65535)), r2});
    cfg_write(REG_TRANS_X, {$urandom(), tx});
    cfg_write(REG_TRANS_Y, {$urandom(), ty});
    cfg_write(REG_TRANS_DEPTH, {$urandom(), td});
    cfg_write(REG_CENTER_X, {$urandom(), 20'($urandom_range(0, 1048575)), cx});
    cfg_write(REG_CENTER_Y, {$urandom(), 20'($urandom_range(0, 1048575)), cy});
  endtask

  // Hold until every expected result is back and the pipeline has drained
  task automatic drain();
    while (result_q.size() != 0 || tag_q.size() != 0) @(posedge clk);
    repeat (Latency + 5) @(posedge clk);
  endtask

  // Offer one point and hold it until accepted, then idle for a random gap unless no_gap is set
  task automatic offer_point(point_row_t row, bit no_gap);
    point_tag_t tg;
    int         gap;
    tg.typed = row.typed;
    tg.res = row.res;
    tag_q.push_back(tg);
    pin_bus.valid <= 1'b1;
    pin_bus.pos_x <= row.x;
    pin_bus.pos_height <= row.h;
    pin_bus.pos_z <= row.z;
    do @(posedge clk); while (!pin_bus.ready);
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      pin_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom_range(0, 2097151)) - 32'sd1048576;
      2: return $signed($urandom_range(0, 33554431)) - 32'sd16777216;
      default: return $signed($urandom_range(0, 1023)) - 32'sd512;
    endcase
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 3))
      0: return 16'($urandom());
      1: return 16'($urandom_range(0, 511) - 256);
      2: return 16'h0100;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_offs();
    if ($urandom_range(0, 2) == 0) return $urandom();
    return $signed($urandom_range(0, 262143)) - 32'sd65536;
  endfunction

  task automatic random_points(int count, bit no_gap);
    point_row_t row;
    row.typed = 1'b0;
    row.res = '0;
    for (int i = 0; i < count; i++) begin
      row.x = rand_coord();
      row.h = rand_coord();
      row.z = rand_coord();
      offer_point(row, no_gap);
    end
    pin_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  point_row_t zero_rows[$];
  point_row_t cam_rows[$];

  initial begin
    point_row_t row;
    result_t    zr;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pin_bus.valid = 1'b0;
    pin_bus.pos_x = '0;
    pin_bus.pos_height = '0;
    pin_bus.pos_z = '0;
    cam = '0;
    fail_count = 0;
    cycle_count = 0;
    stall_req = 1'b0;
    stall_done = 1'b0;
    rx_steady = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // After reset the camera is all zero: every point lands at depth 0
    zr = '0;
    zero_rows = '{
      '{32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b1, zr},
      '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, zr},
      '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1, zr},
      '{32'shFFFF_FFFF, 32'sh0000_00FF, 32'sh0001_0000, 1'b1, zr}
    };
    foreach (zero_rows[i]) offer_point(zero_rows[i], 1'b0);
    pin_bus.valid <= 1'b0;
    @(posedge clk);
    drain();

    // Unit camera: depth follows z, world x and y follow x and height
    load_camera(48'h0000_0000_0100, 48'h0000_0100_0000, 48'h0100_0000_0000,
                32'd0, 32'd0, 32'd0, 12'd160, 12'd120);
    zr = '0;
    zr.depth_out = 32'd255;
    cam_rows = '{
      // depth exactly at the visibility threshold
      '{32'sh0000_0000, 32'sh0000_0000, 32'sh0001_0000, 1'b1,
        '{1'b1, 32'd160, 32'd120, 17'h10000, 32'd256}},
      // one below the threshold: invisible, depth still reported
      '{32'sh0000_0000, 32'sh0000_0000, 32'sh0000_FF00, 1'b1, zr},
      '{32'sh0001_0000, 32'shFFFF_0000, 32'sh0001_0000, 1'b0, '0},
      '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0002_0000, 1'b0, '0},
      '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, '0},
      // large shifted numerators of both signs before the divide
      '{32'sh4000_0000, 32'shC000_0000, 32'sh0001_0000, 1'b0, '0},
      '{32'sh0123_4567, 32'shFEDC_BA98, 32'sh0000_0100, 1'b0, '0},
      '{32'sh0000_0000, 32'sh0000_0000, 32'shFFFF_0000, 1'b0, '0},
      '{32'sh0000_00FF, 32'shFFFF_FF01, 32'sh0100_0000, 1'b0, '0},
      '{32'sh7FFF_FF00, 32'sh0000_0000, 32'sh7FFF_FF00, 1'b0, '0}
    };
    foreach (cam_rows[i]) offer_point(cam_rows[i], 1'b0);
    pin_bus.valid <= 1'b0;
    @(posedge clk);
    drain();

    // Extreme camera: largest coefficients, translations and centers
    load_camera(48'h7FFF_8000_7FFF, 48'h8000_7FFF_8000, 48'h0100_8000_7FFF,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 12'd4095, 12'd4095);
    random_points(200, 1'b0);
    drain();
    load_camera(48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 48'h7FFF_0000_0000,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0100, 12'd0, 12'd0);
    random_points(150, 1'b1);
    drain();

    // Random cameras; one phase under a long receiver hold-off
    for (int ph = 0; ph < 5; ph++) begin
      load_camera({rand_coef(), rand_coef(), rand_coef()},
                  {rand_coef(), rand_coef(), rand_coef()},
                  {rand_coef(), rand_coef(),
                   16'(16'h0100 + ($urandom_range(0, 255) - 128))},
                  rand_offs(), rand_offs(), rand_offs(),
                  12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
      if (ph == 1) stall_req = 1'b1;
      rx_steady = (ph == 3);
      random_points(230, ph == 2);
      drain();
    end

    drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/ptp_pkg.sv
sv/ptp_if.sv
sv/ptp_regs.sv
sv/ptp_front.sv
sv/ptp_back.sv
sv/point_transform_project_unit.sv
sim/tb_point_transform_project_unit.sv
